// ===== hdl/swm_pkg.sv =====
// Shared constants and controller/datapath interface types for the sliding window maximum.
`timescale 1ns / 1ps

package swm_pkg;

    // Default number of samples the window can hold.
    localparam int SWM_WINDOW_MAX = 64;
    // Default sample width in bits.
    localparam int SWM_DATA_WIDTH = 32;
    // Width of the window size register.
    localparam int SWM_CFG_W = 7;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // take the input item, clearing window state on a start flag
        logic rd_back;    // read the back candidate
        logic drop_back;  // drop the back candidate
        logic push;       // append the sample to the queue and the history
        logic fetch;      // read the front candidate and the oldest history sample
        logic emit;       // load the result register, retire the front if it leaves
    } swm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;    // candidate queue is empty
        logic back_smaller;  // back candidate read is smaller than the sample
        logic fill_short;    // window not yet full after this sample
        logic out_free;      // result register can take a new item
    } swm_status_t;

endpackage

// ===== hdl/sliding_window_maximum_top.sv =====
// Top level of the sliding window maximum: controller and datapath.
//
//   Channel   Direction  Carries
//   s_*       in         sample (tdata), start_req (tuser)
//   m_*       out        window_max (tdata)
//   cfg_*     in         window_size register write
//
// After an item is accepted, the controller reads and compares back candidates one at a time
// (a read state then a compare state on the single-port queue memory), pushes the sample,
// fetches the front candidate and loads the result; the input is ready from then on.
// An item that does not yet fill the window frees the input once it has been pushed.
// Reset clears the queue and window pointers and sets the window size to 1.
// A stalled result waits in the output register while the next item is taken; the result
// after it holds the controller, and so the input, until the register is free.
`timescale 1ns / 1ps

module sliding_window_maximum_top
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX = SWM_WINDOW_MAX,
    parameter int DATA_WIDTH = SWM_DATA_WIDTH
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [SWM_CFG_W-1:0]               cfg_wr_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [((DATA_WIDTH+7)/8)*8-1:0]    s_tdata,   // sample
    input  logic                               s_tuser,   // start_req
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [((DATA_WIDTH+7)/8)*8-1:0]    m_tdata    // window_max
);

    localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

    swm_cmd_t              cmd;
    swm_status_t           status;
    logic [DATA_WIDTH-1:0] out_data;

    // Sequencing.
    swm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Storage and arithmetic.
    swm_datapath #(
        .WINDOW_MAX (WINDOW_MAX),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_sample   (s_tdata[DATA_WIDTH-1:0]),
        .in_start    (s_tuser),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (out_data)
    );

    // Result padded to whole bytes.
    assign m_tdata = TDATA_W'(out_data);

endmodule

// ===== hdl/swm_ctrl.sv =====
// Controller state machine that sequences one sample through the datapath.
`timescale 1ns / 1ps

module swm_ctrl
    import swm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  swm_status_t status,
    output swm_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RD    = 3'd1;
    localparam logic [2:0] ST_CMP   = 3'd2;
    localparam logic [2:0] ST_PUSH  = 3'd3;
    localparam logic [2:0] ST_FETCH = 3'd4;
    localparam logic [2:0] ST_FRONT = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Input is taken only between items.
    assign in_ready = (state_reg == ST_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                if (status.count_zero)
                begin
                    state_next = ST_PUSH;
                end
                else
                begin
                    cmd.rd_back = 1'b1;
                    state_next  = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (status.back_smaller)
                begin
                    cmd.drop_back = 1'b1;
                    state_next    = ST_RD;
                end
                else
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                cmd.push = 1'b1;
                if (status.fill_short)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_FRONT;
            end
            ST_FRONT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/swm_datapath.sv =====
// Datapath: candidate queue and history memories, pointers, window register and result register.
`timescale 1ns / 1ps

module swm_datapath
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX = SWM_WINDOW_MAX,
    parameter int DATA_WIDTH = SWM_DATA_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [SWM_CFG_W-1:0]  cfg_wr_data,
    input  logic [DATA_WIDTH-1:0] in_sample,
    input  logic                  in_start,
    input  swm_cmd_t              cmd,
    output swm_status_t           status,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_WIDTH-1:0] out_data
);

    localparam int ADDR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W  = ((CNT_W > ADDR_W) ? CNT_W : ADDR_W) + 1;
    localparam int WW     = (CNT_W > SWM_CFG_W) ? CNT_W : SWM_CFG_W;

    // Storage.
    logic [DATA_WIDTH-1:0] cand_mem [WINDOW_MAX];
    logic [DATA_WIDTH-1:0] rec_mem  [WINDOW_MAX];

    logic [SWM_CFG_W-1:0]  win_size_reg;
    logic [DATA_WIDTH-1:0] sample_reg;
    logic [ADDR_W-1:0]     head_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [ADDR_W-1:0]     ptr_reg;
    logic [CNT_W-1:0]      filled_reg;
    logic [ADDR_W-1:0]     oldest_reg;
    logic [DATA_WIDTH-1:0] cand_rd_reg;
    logic [DATA_WIDTH-1:0] rec_rd_reg;
    logic [DATA_WIDTH-1:0] out_data_reg;
    logic                  out_valid_reg;

    logic [SUM_W-1:0]  tail_sum;
    logic [SUM_W-1:0]  back_sum;
    logic [SUM_W-1:0]  old_sum;
    logic [ADDR_W-1:0] tail_addr;
    logic [ADDR_W-1:0] back_addr;
    logic [ADDR_W-1:0] push_addr;
    logic [ADDR_W-1:0] oldest_addr;
    logic [ADDR_W-1:0] head_inc;
    logic [ADDR_W-1:0] ptr_inc;
    logic              count_full;
    logic [WW-1:0]     cfg_ext;
    logic [WW-1:0]     eff_win;
    logic [WW-1:0]     len;

    // Ring address arithmetic, wrapped at the queue depth.
    always_comb
    begin
        tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
        if (tail_sum >= SUM_W'(WINDOW_MAX))
        begin
            tail_sum = tail_sum - SUM_W'(WINDOW_MAX);
        end
        tail_addr = tail_sum[ADDR_W-1:0];

        back_sum = SUM_W'(head_reg) + SUM_W'(count_reg) - SUM_W'(1);
        if (back_sum >= SUM_W'(WINDOW_MAX))
        begin
            back_sum = back_sum - SUM_W'(WINDOW_MAX);
        end
        back_addr = back_sum[ADDR_W-1:0];

        if (SUM_W'(ptr_reg) >= SUM_W'(filled_reg))
        begin
            old_sum = SUM_W'(ptr_reg) - SUM_W'(filled_reg);
        end
        else
        begin
            old_sum = SUM_W'(ptr_reg) + SUM_W'(WINDOW_MAX) - SUM_W'(filled_reg);
        end
        oldest_addr = old_sum[ADDR_W-1:0];

        head_inc = (head_reg == ADDR_W'(WINDOW_MAX - 1)) ? '0 : head_reg + ADDR_W'(1);
        ptr_inc  = (ptr_reg == ADDR_W'(WINDOW_MAX - 1)) ? '0 : ptr_reg + ADDR_W'(1);

        // A full queue drops its front, so the new sample lands on the old head.
        count_full = (count_reg == CNT_W'(WINDOW_MAX));
        push_addr  = count_full ? head_reg : tail_addr;
    end

    // Effective window length and fill check.
    always_comb
    begin
        cfg_ext = WW'(win_size_reg);
        if (cfg_ext == '0)
        begin
            eff_win = WW'(1);
        end
        else if (cfg_ext > WW'(WINDOW_MAX))
        begin
            eff_win = WW'(WINDOW_MAX);
        end
        else
        begin
            eff_win = cfg_ext;
        end
        len = WW'(filled_reg) + WW'(1);
    end

    // Status to the controller.
    always_comb
    begin
        status.count_zero   = (count_reg == '0);
        status.back_smaller = ($signed(sample_reg) > $signed(cand_rd_reg));
        status.fill_short   = (len < eff_win);
        status.out_free     = !out_valid_reg || out_ready;
    end

    // Window size register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_size_reg <= SWM_CFG_W'(1);
        end
        else if (cfg_wr_en)
        begin
            win_size_reg <= cfg_wr_data;
        end
    end

    // Queue and history pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            count_reg  <= '0;
            ptr_reg    <= '0;
            filled_reg <= '0;
        end
        else
        begin
            if (cmd.load && in_start)
            begin
                head_reg   <= '0;
                count_reg  <= '0;
                ptr_reg    <= '0;
                filled_reg <= '0;
            end
            if (cmd.drop_back)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
            if (cmd.push)
            begin
                if (count_full)
                begin
                    head_reg <= head_inc;
                end
                else
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                ptr_reg <= ptr_inc;
                if (status.fill_short)
                begin
                    filled_reg <= filled_reg + CNT_W'(1);
                end
            end
            if (cmd.emit && (cand_rd_reg == rec_rd_reg))
            begin
                head_reg  <= head_inc;
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // Sample and address holding registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg <= in_sample;
        end
        if (cmd.push)
        begin
            oldest_reg <= oldest_addr;
        end
    end

    // Candidate queue memory.
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            cand_mem[push_addr] <= sample_reg;
        end
        if (cmd.rd_back)
        begin
            cand_rd_reg <= cand_mem[back_addr];
        end
        else if (cmd.fetch)
        begin
            cand_rd_reg <= cand_mem[head_reg];
        end
    end

    // History memory.
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            rec_mem[ptr_reg] <= sample_reg;
        end
        if (cmd.fetch)
        begin
            rec_rd_reg <= rec_mem[oldest_reg];
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg <= cand_rd_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the sliding window maximum, with its own window model.
`timescale 1ns / 1ps

module tb;
    import swm_pkg::*;

    localparam int DATA_W      = SWM_DATA_WIDTH;
    localparam int TDATA_W     = ((DATA_W + 7) / 8) * 8;
    localparam int WIN_DEPTH   = SWM_WINDOW_MAX;
    localparam int DRAIN_WAIT  = 5 + 2 * WIN_DEPTH + 30;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SHOW_LIMIT  = 10;

    localparam logic [DATA_W-1:0] MOST_POSITIVE = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] MOST_NEGATIVE = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] MINUS_ONE     = {DATA_W{1'b1}};

    typedef enum int {
        STYLE_WIDE,
        STYLE_NARROW,
        STYLE_FALLING,
        STYLE_RISING,
        STYLE_EXTREME
    } sample_style_t;

    // Tracks the window as the block should, and holds the maxima still to arrive.
    class window_max_tracker;
        logic [SWM_CFG_W-1:0] window_reg;
        logic [DATA_W-1:0]    cand_vals [WIN_DEPTH];
        int unsigned          cand_head;
        int unsigned          cand_count;
        logic [DATA_W-1:0]    hist_vals [WIN_DEPTH];
        int unsigned          hist_ptr;
        int unsigned          filled;
        logic [DATA_W-1:0]    pending_max [$];
        int                   fail_count;
        int                   shown;

        function new();
            window_reg = SWM_CFG_W'(1);
            fail_count = 0;
            shown      = 0;
            clear_window();
        endfunction

        function void clear_window();
            foreach (cand_vals[i]) cand_vals[i] = '0;
            foreach (hist_vals[i]) hist_vals[i] = '0;
            cand_head  = 0;
            cand_count = 0;
            hist_ptr   = 0;
            filled     = 0;
        endfunction

        function void set_window(logic [SWM_CFG_W-1:0] value);
            window_reg = value;
        endfunction

        // Steps the window with one accepted item and notes the maximum it gives.
        function void take_sample(logic [DATA_W-1:0] smp, logic first);
            int unsigned win_len;
            int unsigned len;
            int unsigned oldest;
            int unsigned back;
            bit          popping;
            win_len = (window_reg == 0) ? 1 :
                      ((window_reg > WIN_DEPTH) ? WIN_DEPTH : window_reg);
            if (first)
                clear_window();

            // Smaller candidates leave from the back; equal ones stay.
            popping = 1'b1;
            while (popping && cand_count > 0)
            begin
                back = (cand_head + cand_count - 1) % WIN_DEPTH;
                if ($signed(smp) > $signed(cand_vals[back]))
                    cand_count--;
                else
                    popping = 1'b0;
            end
            if (cand_count >= WIN_DEPTH)
            begin
                cand_head = (cand_head + 1) % WIN_DEPTH;
                cand_count--;
            end
            cand_vals[(cand_head + cand_count) % WIN_DEPTH] = smp;
            cand_count++;

            // The oldest sample of the window that now ends at this one.
            oldest = (hist_ptr + WIN_DEPTH - filled) % WIN_DEPTH;
            hist_vals[hist_ptr] = smp;
            hist_ptr = (hist_ptr + 1) % WIN_DEPTH;
            len = filled + 1;
            if (len < win_len)
            begin
                filled = len;
                return;
            end
            pending_max.insert(pending_max.size(), cand_vals[cand_head]);
            if (cand_vals[cand_head] == hist_vals[oldest])
            begin
                cand_head = (cand_head + 1) % WIN_DEPTH;
                cand_count--;
            end
            filled = len - 1;
        endfunction

        // Compares one delivered maximum with the oldest one waiting.
        function void check_max(logic [DATA_W-1:0] got);
            logic [DATA_W-1:0] want;
            if (pending_max.size() == 0)
            begin
                fail_count++;
                if (shown < SHOW_LIMIT)
                    $display("Unexpected result item: window_max %0d", $signed(got));
                shown++;
                return;
            end
            want = pending_max[0];
            pending_max.delete(0);
            if (got !== want)
            begin
                fail_count++;
                if (shown < SHOW_LIMIT)
                    $display("window_max mismatch: expected %0d, actual %0d",
                             $signed(want), $signed(got));
                shown++;
            end
        endfunction

        function int pending();
            return pending_max.size();
        endfunction

        // Counts any maxima that never arrived and gives the total of failures.
        function int close_out();
            fail_count += pending_max.size();
            return fail_count;
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [SWM_CFG_W-1:0] cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata;   // sample
    logic                 s_tuser;   // start_req
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TDATA_W-1:0]   m_tdata;   // window_max

    bit sender_idle_on   = 1'b1;
    bit receiver_idle_on = 1'b1;
    bit hold_req         = 1'b0;
    int cycle_count      = 0;

    window_max_tracker tracker = new();

    sliding_window_maximum_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Time-out guard.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Handshakes are sampled mid-cycle, when every input and output is settled.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
                tracker.set_window(cfg_wr_data);
            if (s_tvalid && s_tready)
                tracker.take_sample(s_tdata[DATA_W-1:0], s_tuser);
            if (m_tvalid && m_tready)
                tracker.check_max(m_tdata[DATA_W-1:0]);
        end
    end

    // Result side: random stalls, and one long hold-off when asked for.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end
            else if (receiver_idle_on && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offers one item and returns at the edge that accepts it.
    task automatic send_sample(input logic [DATA_W-1:0] smp, input logic first);
        if (sender_idle_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'(smp);
        s_tuser  <= first;
        @(negedge clk);
        while (!s_tready) @(negedge clk);
        @(posedge clk);
    endtask

    // Lets every expected maximum arrive and the block fall idle.
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_window(input logic [SWM_CFG_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] next_sample(sample_style_t style,
                                                      logic [DATA_W-1:0] prev);
        logic [DATA_W-1:0] pick;
        case (style)
            STYLE_WIDE:    pick = DATA_W'($urandom);
            STYLE_NARROW:  pick = DATA_W'($urandom_range(0, 8)) - DATA_W'(4);
            STYLE_FALLING: pick = prev - DATA_W'($urandom_range(0, 3));
            STYLE_RISING:  pick = prev + DATA_W'($urandom_range(0, 3));
            default:
            begin
                case ($urandom_range(0, 4))
                    0:       pick = MOST_POSITIVE;
                    1:       pick = MOST_NEGATIVE;
                    2:       pick = '0;
                    3:       pick = MINUS_ONE;
                    default: pick = DATA_W'(1);
                endcase
            end
        endcase
        return pick;
    endfunction

    // A run of items: mostly whole sequences, with the odd restart part-way.
    task automatic run_random_phase(input int n_items);
        sample_style_t     style;
        logic [DATA_W-1:0] smp;
        logic              first;
        style = sample_style_t'($urandom_range(0, 4));
        smp   = DATA_W'($urandom);
        for (int i = 0; i < n_items; i++)
        begin
            first = (i == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 39) == 0);
            if (first || $urandom_range(0, 29) == 0)
                style = sample_style_t'($urandom_range(0, 4));
            smp = next_sample(style, smp);
            send_sample(smp, first);
        end
    endtask

    // Main sequence: reset, directed cases, then random phases.
    initial
    begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Window of one after reset: the extremes of the sample range.
        send_sample(MOST_POSITIVE, 1'b1);
        send_sample(MOST_NEGATIVE, 1'b0);
        send_sample('0, 1'b0);
        send_sample(MINUS_ONE, 1'b0);
        send_sample(DATA_W'(1), 1'b0);

        // Equal values in the queue, and a restart part-way.
        wait_quiet();
        write_window(SWM_CFG_W'(3));
        send_sample(DATA_W'(5), 1'b1);
        send_sample(DATA_W'(5), 1'b0);
        send_sample(DATA_W'(5), 1'b0);
        send_sample(DATA_W'(2), 1'b0);
        send_sample(DATA_W'(9), 1'b0);
        send_sample(MOST_NEGATIVE, 1'b0);
        send_sample(MOST_NEGATIVE, 1'b0);
        send_sample(DATA_W'(7), 1'b1);
        send_sample(DATA_W'(3), 1'b0);

        // A window size of zero behaves as one.
        wait_quiet();
        write_window(SWM_CFG_W'(0));
        send_sample(-DATA_W'(5), 1'b1);
        send_sample(DATA_W'(6), 1'b0);

        // The window grows when its size is raised part-way through a sequence.
        wait_quiet();
        write_window(SWM_CFG_W'(2));
        send_sample(DATA_W'(10), 1'b1);
        send_sample(DATA_W'(4), 1'b0);
        wait_quiet();
        write_window(SWM_CFG_W'(4));
        send_sample(DATA_W'(3), 1'b0);
        send_sample(DATA_W'(8), 1'b0);
        send_sample(DATA_W'(1), 1'b0);
        send_sample(DATA_W'(2), 1'b0);

        // Lowering the size part-way keeps the current window length.
        wait_quiet();
        write_window(SWM_CFG_W'(2));
        send_sample(DATA_W'(7), 1'b0);
        send_sample('0, 1'b0);

        // A size above the maximum saturates.
        wait_quiet();
        write_window(SWM_CFG_W'(127));
        send_sample(MINUS_ONE, 1'b1);
        send_sample(MOST_POSITIVE, 1'b0);

        // Random phases over several window sizes; the last ones run without idling.
        for (int p = 0; p < 12; p++)
        begin
            wait_quiet();
            case (p)
                0, 6, 11: write_window(SWM_CFG_W'(WIN_DEPTH));
                1:        write_window(SWM_CFG_W'(1));
                2:        write_window(SWM_CFG_W'(127));
                3:        write_window(SWM_CFG_W'(0));
                default:  write_window(SWM_CFG_W'($urandom_range(2, WIN_DEPTH - 1)));
            endcase
            if (p >= 10)
            begin
                sender_idle_on   = 1'b0;
                receiver_idle_on = 1'b0;
            end
            if (p == 6)
                hold_req = 1'b1;
            run_random_phase(118);
        end

        wait_quiet();
        if (tracker.close_out() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/swm_pkg.sv
hdl/swm_ctrl.sv
hdl/swm_datapath.sv
hdl/sliding_window_maximum_top.sv
bench/tb.sv
